// ===== src/tpce_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text panel cursor engine package
// Shared types, geometry constants, command encoding and the symbol table.
// ----------------------------------------------------------------------------
package tpce_pkg;

    localparam int LINE_COLUMNS = 24;
    localparam int LINE_ROWS    = 4;

    localparam logic [4:0]  COL_LIM      = 5'(LINE_COLUMNS + 1);
    localparam logic [4:0]  COL_WRAP     = 5'(LINE_COLUMNS);
    localparam logic [3:0]  ROW_LIM      = 4'(LINE_ROWS);
    localparam logic [3:0]  END_ROWS_MAX = 4'd4;
    localparam int          BAND_STEP    = LINE_ROWS * 32 + 16;
    localparam logic [10:0] PANEL_BOTTOM = 11'd271;
    localparam logic [20:0] CP_NEWLINE   = 21'd10;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int SYM_COUNT  = 59;

    localparam logic [1:0] MODE_BEGIN = 2'd0;
    localparam logic [1:0] MODE_CHAR  = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    typedef enum logic [2:0] {
        OP_GLYPH = 3'd0,
        OP_PAD   = 3'd1,
        OP_MOVE  = 3'd2,
        OP_FLUSH = 3'd3,
        OP_FILL  = 3'd4,
        OP_FG    = 3'd5,
        OP_BG    = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        KIND_BEGIN   = 2'd0,
        KIND_GLYPH   = 2'd1,
        KIND_NEWLINE = 2'd2,
        KIND_END     = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]        mode;
        logic [20:0]       code_point;
        logic signed [3:0] slot_colour;
        logic [2:0]        band_sel;
    } t_in;

    typedef struct packed {
        t_op        op;
        logic [7:0] glyph;
        logic [4:0] pad_count;
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
        logic [8:0] band_bottom;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_out;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] off;
        logic [3:0] sc;
        logic [7:0] glyph;
        logic [4:0] col;
        logic [2:0] row;
        logic       move;
        logic [2:0] nrows;
    } t_cmd;

    localparam logic [15:0] SYM_CODE [0:SYM_COUNT-1] = '{
        16'h263a, 16'h263b, 16'h2665, 16'h25c6, 16'h2663, 16'h2660, 16'h25cf, 16'h25c8,
        16'h25ef, 16'h25d9, 16'h2642, 16'h2640, 16'h266a, 16'h266b, 16'h263c, 16'h25b6,
        16'h25c0, 16'h2195, 16'h203c, 16'h00b6, 16'h00a7, 16'h2580, 16'h21a8, 16'h2191,
        16'h2193, 16'h2192, 16'h2190, 16'h250c, 16'h2194, 16'h25b2, 16'h25bc, 16'h2588,
        16'h20ac, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021, 16'h02c6,
        16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017d, 16'h2018, 16'h2019, 16'h201c,
        16'h201d, 16'h2022, 16'h2013, 16'h2014, 16'h02dc, 16'h2122, 16'h0161, 16'h203a,
        16'h0153, 16'h017e, 16'h0178
    };

    localparam logic [7:0] SYM_GLYPH [0:SYM_COUNT-1] = '{
        8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
        8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10,
        8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
        8'h19, 8'h1a, 8'h1b, 8'h1c, 8'h1d, 8'h1e, 8'h1f, 8'h7f,
        8'h80, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88,
        8'h89, 8'h8a, 8'h8b, 8'h8c, 8'h8e, 8'h91, 8'h92, 8'h93,
        8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a, 8'h9b,
        8'h9c, 8'h9e, 8'h9f
    };

    function automatic logic [7:0] map_glyph(input logic [20:0] cp);
        logic [7:0] g;
        if (cp inside {[21'h20:21'h7d], [21'ha1:21'hff]}) begin
            g = cp[7:0];
        end else begin
            g = 8'h20;
        end
        for (int i = 0; i < SYM_COUNT; i++) begin
            if (cp == {5'd0, SYM_CODE[i]}) begin
                g = SYM_GLYPH[i];
            end
        end
        return g;
    endfunction

endpackage
`default_nettype wire

// ===== src/tpce_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text panel cursor engine front end
// Accepts events, tracks column, row and band, and issues expansion commands.
// ----------------------------------------------------------------------------
module tpce_front import tpce_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_in  i_item,
    input  wire logic i_q_full,
    output logic      o_cmd_push,
    output t_cmd      o_cmd
);

    logic [4:0] r_col, n_col;
    logic [2:0] r_row, n_row;
    logic [2:0] r_off, n_off;

    logic       accept;
    logic       gen;
    logic [4:0] end_col;
    logic [2:0] end_row;
    logic [3:0] rem_rows;
    logic [3:0] row_next;

    function automatic logic [2:0] row_inc(input logic [2:0] r);
        return (r == 3'd7) ? r : r + 3'd1;
    endfunction

    always_comb begin
        accept   = i_push && !i_q_full;
        gen      = 1'b0;
        n_col    = r_col;
        n_row    = r_row;
        n_off    = r_off;
        o_cmd    = '0;
        o_cmd.off = r_off;
        end_col  = r_col;
        end_row  = r_row;
        rem_rows = '0;
        row_next = {1'b0, r_row} + 4'd1;
        case (i_item.mode)
            MODE_BEGIN: begin
                n_col     = '0;
                n_row     = '0;
                n_off     = i_item.band_sel;
                gen       = 1'b1;
                o_cmd.kind = KIND_BEGIN;
                o_cmd.off  = i_item.band_sel;
                o_cmd.sc   = i_item.slot_colour;
            end
            MODE_CHAR: begin
                if (i_item.code_point == CP_NEWLINE) begin
                    gen        = ({1'b0, r_row} < ROW_LIM);
                    o_cmd.kind = KIND_NEWLINE;
                    o_cmd.col  = r_col;
                    o_cmd.row  = row_next[2:0];
                    o_cmd.move = (row_next < ROW_LIM);
                    n_col      = '0;
                    n_row      = row_inc(r_row);
                end else begin
                    gen         = ({1'b0, r_row} < ROW_LIM) && (r_col < COL_LIM);
                    o_cmd.kind  = KIND_GLYPH;
                    o_cmd.glyph = map_glyph(i_item.code_point);
                    n_col       = (r_col == 5'd31) ? r_col : r_col + 5'd1;
                end
            end
            MODE_END: begin
                if (r_col >= COL_WRAP) begin
                    end_col = '0;
                    end_row = row_inc(r_row);
                end
                gen        = 1'b1;
                o_cmd.kind = KIND_END;
                o_cmd.col  = end_col;
                o_cmd.row  = end_row;
                if ({1'b0, end_row} < ROW_LIM) begin
                    rem_rows    = ROW_LIM - {1'b0, end_row};
                    o_cmd.nrows = (rem_rows > END_ROWS_MAX) ? END_ROWS_MAX[2:0]
                                                            : rem_rows[2:0];
                    n_row       = ROW_LIM[2:0];
                    n_col       = '0;
                end else begin
                    n_row = end_row;
                    n_col = end_col;
                end
            end
            default: begin
                gen = 1'b0;
            end
        endcase
        o_cmd_push = accept && gen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_off <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_off <= n_off;
        end
    end

endmodule
`default_nettype wire

// ===== src/tpce_cmdq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text panel cursor engine command queue
// Short FIFO between the front end and the expansion back end.
// ----------------------------------------------------------------------------
module tpce_cmdq import tpce_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);

    t_cmd                 r_mem [0:CMDQ_DEPTH-1];
    logic [CMDQ_AW-1:0]   r_wp;
    logic [CMDQ_AW-1:0]   r_rp;
    logic [CMDQ_AW:0]     r_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_cnt == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (CMDQ_AW+1)'(do_push) - (CMDQ_AW+1)'(do_pop);
        end
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== src/tpce_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text panel cursor engine back end
// Expands commands into panel operations, one beat a cycle while the result FIFO has room.
// ----------------------------------------------------------------------------
module tpce_back import tpce_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out      o_res
);

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state     r_state, n_state;
    t_cmd       r_cmd, n_cmd;
    logic [2:0] r_step, n_step;

    t_out       r_oq [0:1];
    logic       r_owp, r_orp;
    logic [1:0] r_ocnt;

    logic        op_v;
    t_out        op;
    logic        out_pop;
    logic [10:0] t0, t1, t2, ymv;
    logic [7:0]  r1, g1, b1, r2, g2, b2, fg;
    logic        none_sel;

    function automatic logic [10:0] band_y(input logic [2:0] off, input logic [2:0] row);
        return 11'(off) * 11'(BAND_STEP) + {3'd0, row, 5'd0};
    endfunction

    function automatic logic [8:0] clamp_y(input logic [10:0] y);
        return (y > PANEL_BOTTOM) ? PANEL_BOTTOM[8:0] : y[8:0];
    endfunction

    function automatic logic [4:0] pad_for(input logic [4:0] col);
        return (col < COL_LIM) ? COL_LIM - col : 5'd0;
    endfunction

    function automatic logic [9:0] pix_x(input logic [4:0] col);
        return 10'(col) * 10'd19 + 10'd4;
    endfunction

    assign out_pop = i_pop && (r_ocnt != 2'd0);
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_oq[r_orp];

    always_comb begin
        t0  = band_y(r_cmd.off, 3'd0);
        t1  = t0 + 11'd34;
        t2  = band_y(r_cmd.off, ROW_LIM[2:0]);
        ymv = band_y(r_cmd.off, r_cmd.row);

        none_sel = (r_cmd.sc[2:0] == 3'd0);
        if (r_cmd.sc[3]) begin
            r1 = 8'h00; g1 = 8'h00; b1 = 8'h00;
            r2 = 8'h00; g2 = 8'h00; b2 = 8'h00;
        end else if (none_sel) begin
            r1 = 8'h88; g1 = 8'h90; b1 = 8'h88;
            r2 = 8'hb0; g2 = 8'ha0; b2 = 8'hb0;
        end else begin
            r1 = r_cmd.sc[0] ? 8'h90 : 8'h00;
            g1 = r_cmd.sc[1] ? 8'h90 : 8'h00;
            b1 = r_cmd.sc[2] ? 8'h90 : 8'h00;
            r2 = r_cmd.sc[0] ? 8'hff : 8'h00;
            g2 = r_cmd.sc[1] ? 8'hff : 8'h00;
            b2 = r_cmd.sc[2] ? 8'hff : 8'h00;
        end
        fg = (g1 > 8'h88) ? 8'h01 : 8'hff;

        n_state   = r_state;
        n_cmd     = r_cmd;
        n_step    = r_step;
        o_cmd_pop = 1'b0;
        op_v      = 1'b0;
        op        = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd     = i_cmd;
                    n_step    = '0;
                    n_state   = ST_RUN;
                    o_cmd_pop = 1'b1;
                end
            end
            ST_RUN: begin
                if (r_ocnt != 2'd2) begin
                    op_v   = 1'b1;
                    n_step = r_step + 3'd1;
                    case (r_cmd.kind)
                        KIND_BEGIN: begin
                            case (r_step)
                                3'd0: begin
                                    op.op          = OP_FILL;
                                    op.pixel_y     = {1'b0, clamp_y(t0)};
                                    op.band_bottom = clamp_y(t1);
                                    op.red         = r1;
                                    op.green       = g1;
                                    op.blue        = b1;
                                end
                                3'd1: begin
                                    op.op          = OP_FILL;
                                    op.pixel_y     = {1'b0, clamp_y(t1)};
                                    op.band_bottom = clamp_y(t2);
                                    op.red         = r2;
                                    op.green       = g2;
                                    op.blue        = b2;
                                end
                                3'd2: begin
                                    op.op    = OP_FG;
                                    op.red   = fg;
                                    op.green = fg;
                                    op.blue  = fg;
                                end
                                3'd3: begin
                                    op.op = OP_BG;
                                end
                                default: begin
                                    op.op      = OP_MOVE;
                                    op.pixel_x = pix_x(5'd0);
                                    op.pixel_y = t0[9:0];
                                    op.last    = 1'b1;
                                end
                            endcase
                        end
                        KIND_GLYPH: begin
                            op.op    = OP_GLYPH;
                            op.glyph = r_cmd.glyph;
                            op.last  = 1'b1;
                        end
                        KIND_NEWLINE: begin
                            if (r_step == 3'd0) begin
                                op.op        = OP_PAD;
                                op.pad_count = pad_for(r_cmd.col);
                                op.last      = !r_cmd.move;
                            end else begin
                                op.op      = OP_MOVE;
                                op.pixel_x = pix_x(5'd0);
                                op.pixel_y = ymv[9:0];
                                op.last    = 1'b1;
                            end
                        end
                        default: begin
                            if (r_cmd.nrows == 3'd0) begin
                                op.op   = OP_FLUSH;
                                op.last = 1'b1;
                            end else if (!r_step[0]) begin
                                op.op      = OP_MOVE;
                                op.pixel_x = pix_x(r_cmd.col);
                                op.pixel_y = ymv[9:0];
                            end else begin
                                op.op        = OP_PAD;
                                op.pad_count = pad_for(r_cmd.col);
                                n_cmd.row    = r_cmd.row + 3'd1;
                                n_cmd.col    = '0;
                                n_cmd.nrows  = r_cmd.nrows - 3'd1;
                                n_step       = '0;
                            end
                        end
                    endcase
                    if (op.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_owp   <= 1'b0;
            r_orp   <= 1'b0;
            r_ocnt  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (op_v) begin
                r_owp <= ~r_owp;
            end
            if (out_pop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + 2'(op_v) - 2'(out_pop);
        end
        r_cmd <= n_cmd;
        if (op_v) begin
            r_oq[r_owp] <= op;
        end
    end

`ifndef SYNTH
    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 2'd2)
        else $error("result FIFO overfilled");

    a_load_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_state == ST_RUN))
        else $error("command taken without starting expansion");

    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op_v && op.last) |=> (r_state == ST_IDLE))
        else $error("expansion continued past its last beat");

    a_end_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_cmd.kind == KIND_END) |-> (r_cmd.nrows <= 3'd4))
        else $error("end command with too many rows");
`endif

endmodule
`default_nettype wire

// ===== src/text_panel_cursor_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text panel cursor engine
// Turns begin, character and end events into text panel operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_item and raise i_push; a beat is taken on a clock
//   edge with i_push high and o_full low. Events with no effect on the panel
//   are taken and only update the cursor state.
//   Result channel: while o_empty is low, o_res holds the oldest operation;
//   raise i_pop to take it. o_res.last marks the final operation of an event.
//   The first operation of an event passes through the command queue, the
//   back end's command register and the result FIFO. The back end emits
//   one operation per cycle while the result FIFO has room; each event is
//   loaded, then gives 1 (glyph), 1 or 2 (newline), 5 (begin) or up to 9 (end).
//   A four-deep command queue sits between the front end and the back end,
//   and a two-deep result FIFO drives the outputs; input keeps flowing while
//   results wait, until the queue fills and o_full rises.
//   When the receiver stalls, results hold and the back end stops once the
//   result FIFO is full.
//   Reset (synchronous, active low) clears column, row, band, the queue and
//   the result FIFO; o_empty is high and o_full low right after it.
// ----------------------------------------------------------------------------
module text_panel_cursor_engine import tpce_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_in  i_item,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out      o_res
);

    logic cmd_push;
    t_cmd cmd_in;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    tpce_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (i_item),
        .i_q_full   (o_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    tpce_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (o_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    tpce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire
